FILE: design/mmc_pkg.sv
// mmc_pkg: shared types and constants of the matrix multiply coprocessor
// used by mmc_ctrl, mmc_datapath and matrix_multiply_coprocessor; no dependencies
package mmc_pkg;

  localparam int IDX_W  = 3;   // row and column index width
  localparam int STRIDE = 8;   // entries per store row
  localparam int VAL_W  = 16;  // element and result width
  localparam int SIZE_W = 4;   // active size register width

  localparam logic [1:0] CMD_WRITE_A = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_EXECUTE = 2'd2;

  // element write towards the stores
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } mmc_wr_t;

  // one result element to compute
  typedef struct packed {
    logic              issue;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
    logic [SIZE_W-1:0] size;
  } mmc_issue_t;

  typedef struct packed {
    logic last_done;
  } mmc_status_t;

endpackage

FILE: design/mmc_ctrl.sv
// mmc_ctrl: command decode, active size register and result sequencer
// depends on mmc_pkg
module mmc_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [1:0]                 cmd_i,
  input  logic [mmc_pkg::IDX_W-1:0]  elem_row_i,
  input  logic [mmc_pkg::IDX_W-1:0]  elem_col_i,
  input  logic [mmc_pkg::VAL_W-1:0]  elem_value_i,
  input  logic                       cfg_valid_i,
  input  logic [mmc_pkg::SIZE_W-1:0] cfg_data_i,
  input  mmc_pkg::mmc_status_t       status_i,
  output logic                       busy_o,
  output logic                       cfg_ready_o,
  output mmc_pkg::mmc_wr_t           wr_o,
  output mmc_pkg::mmc_issue_t        issue_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [mmc_pkg::SIZE_W-1:0] active_q;
  logic [mmc_pkg::SIZE_W-1:0] size_n;
  logic [mmc_pkg::SIZE_W-1:0] size_q, size_d;
  logic [mmc_pkg::IDX_W-1:0]  i_q, i_d, j_q, j_d;
  logic                       accept;
  logic                       in_range;
  logic                       i_end, j_end;

  // oversized register acts as the maximum
  assign size_n = (active_q > mmc_pkg::SIZE_W'(MAX_DIM)) ?
                  mmc_pkg::SIZE_W'(MAX_DIM) : active_q;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy_o;
  assign accept      = start_i && !busy_o;
  assign in_range    = ({1'b0, elem_row_i} < size_n) && ({1'b0, elem_col_i} < size_n);

  assign wr_o.wr_a  = accept && (cmd_i == mmc_pkg::CMD_WRITE_A) && in_range;
  assign wr_o.wr_b  = accept && (cmd_i == mmc_pkg::CMD_WRITE_B) && in_range;
  assign wr_o.row   = elem_row_i;
  assign wr_o.col   = elem_col_i;
  assign wr_o.value = elem_value_i;

  assign i_end = ({1'b0, i_q} == size_q - mmc_pkg::SIZE_W'(1));
  assign j_end = ({1'b0, j_q} == size_q - mmc_pkg::SIZE_W'(1));

  assign issue_o.issue = (state_q == ST_RUN);
  assign issue_o.row   = i_q;
  assign issue_o.col   = j_q;
  assign issue_o.last  = i_end && j_end;
  assign issue_o.size  = size_q;

  always_comb begin
    state_d = state_q;
    size_d  = size_q;
    i_d     = i_q;
    j_d     = j_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i == mmc_pkg::CMD_EXECUTE) && (size_n != '0)) begin
          state_d = ST_RUN;
          size_d  = size_n;
          i_d     = '0;
          j_d     = '0;
        end
      end
      ST_RUN: begin
        if (j_end) begin
          j_d = '0;
          if (i_end) begin
            state_d = ST_DRAIN;
          end else begin
            i_d = i_q + mmc_pkg::IDX_W'(1);
          end
        end else begin
          j_d = j_q + mmc_pkg::IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // hold off new items until the final result has left the pipeline
        if (status_i.last_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= '0;
      size_q   <= '0;
      i_q      <= '0;
      j_q      <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      i_q     <= i_d;
      j_q     <= j_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
    end
  end

endmodule

FILE: design/mmc_datapath.sv
// mmc_datapath: banked element stores, row of multipliers and adder tree
// depends on mmc_pkg
module mmc_datapath #(
  parameter int MAX_DIM = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mmc_pkg::mmc_wr_t                 wr_i,
  input  mmc_pkg::mmc_issue_t              issue_i,
  output mmc_pkg::mmc_status_t             status_o,
  output logic                             result_valid_o,
  output logic [mmc_pkg::IDX_W-1:0]        out_row_o,
  output logic [mmc_pkg::IDX_W-1:0]        out_col_o,
  output logic signed [mmc_pkg::VAL_W-1:0] product_value_o,
  output logic                             last_o
);

  // lane k of store a holds column k (addressed by row),
  // lane k of store b holds row k (addressed by column)
  logic [mmc_pkg::VAL_W-1:0]  a_mem_q [MAX_DIM][mmc_pkg::STRIDE];
  logic [mmc_pkg::VAL_W-1:0]  b_mem_q [MAX_DIM][mmc_pkg::STRIDE];
  logic [mmc_pkg::STRIDE-1:0] a_vld_q [MAX_DIM];
  logic [mmc_pkg::STRIDE-1:0] b_vld_q [MAX_DIM];

  logic [mmc_pkg::VAL_W-1:0]   a_rd_q [MAX_DIM];
  logic [mmc_pkg::VAL_W-1:0]   b_rd_q [MAX_DIM];
  logic [2*mmc_pkg::VAL_W-1:0] prod_full [MAX_DIM];
  logic [mmc_pkg::VAL_W-1:0]   prod_q [MAX_DIM];
  logic [mmc_pkg::VAL_W-1:0]   sum;

  logic                      s1_vld_q, s2_vld_q, out_vld_q;
  logic [mmc_pkg::IDX_W-1:0] s1_row_q, s1_col_q, s2_row_q, s2_col_q;
  logic                      s1_last_q, s2_last_q;
  logic [mmc_pkg::IDX_W-1:0] out_row_q, out_col_q;
  logic [mmc_pkg::VAL_W-1:0] out_val_q;
  logic                      out_last_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_DIM; k++) begin
      if (wr_i.wr_a && (wr_i.col == mmc_pkg::IDX_W'(k))) begin
        a_mem_q[k][wr_i.row] <= wr_i.value;
      end
      if (wr_i.wr_b && (wr_i.row == mmc_pkg::IDX_W'(k))) begin
        b_mem_q[k][wr_i.col] <= wr_i.value;
      end
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_DIM; k++) begin
        a_vld_q[k] <= '0;
        b_vld_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < MAX_DIM; k++) begin
        if (wr_i.wr_a && (wr_i.col == mmc_pkg::IDX_W'(k))) begin
          a_vld_q[k][wr_i.row] <= 1'b1;
        end
        if (wr_i.wr_b && (wr_i.row == mmc_pkg::IDX_W'(k))) begin
          b_vld_q[k][wr_i.col] <= 1'b1;
        end
      end
    end
  end

  // read stage: lanes beyond the active size contribute zero
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_DIM; k++) begin
      if (a_vld_q[k][issue_i.row] && (mmc_pkg::SIZE_W'(k) < issue_i.size)) begin
        a_rd_q[k] <= a_mem_q[k][issue_i.row];
      end else begin
        a_rd_q[k] <= '0;
      end
      if (b_vld_q[k][issue_i.col] && (mmc_pkg::SIZE_W'(k) < issue_i.size)) begin
        b_rd_q[k] <= b_mem_q[k][issue_i.col];
      end else begin
        b_rd_q[k] <= '0;
      end
    end
  end

  // multiply stage, only the low half is kept
  always_comb begin
    for (int k = 0; k < MAX_DIM; k++) begin
      prod_full[k] = a_rd_q[k] * b_rd_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_DIM; k++) begin
      prod_q[k] <= prod_full[k][mmc_pkg::VAL_W-1:0];
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < MAX_DIM; k++) begin
      sum = sum + prod_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q   <= issue_i.row;
    s1_col_q   <= issue_i.col;
    s1_last_q  <= issue_i.last;
    s2_row_q   <= s1_row_q;
    s2_col_q   <= s1_col_q;
    s2_last_q  <= s1_last_q;
    out_row_q  <= s2_row_q;
    out_col_q  <= s2_col_q;
    out_last_q <= s2_last_q;
    out_val_q  <= sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= issue_i.issue;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  assign result_valid_o     = out_vld_q;
  assign out_row_o          = out_row_q;
  assign out_col_o          = out_col_q;
  assign product_value_o    = out_val_q;
  assign last_o             = out_vld_q && out_last_q;
  assign status_o.last_done = out_vld_q && out_last_q;

endmodule

FILE: design/matrix_multiply_coprocessor.sv
// matrix_multiply_coprocessor: top level, square signed 16-bit matrix multiply
// depends on mmc_pkg, mmc_ctrl and mmc_datapath
//
// usage
//   command channel: an item is taken when start_i is high and busy_o is low.
//   cmd_i selects write of an a element, write of a b element, or execute.
//   writes outside the active size, and the unused code, are dropped.
//   a write leaves busy_o low, so writes can stream.
//   execute walks c = a*b over the active size n, one element per cycle in
//   row-major order; each element passes the read, product and output
//   registers after it is issued, and the results follow back to back.
//   the row of MAX_DIM multipliers and the adder tree set that one per cycle.
//   busy_o stays high through the strobe of the final element (last_o high).
//   an execute with size zero gives nothing and does not raise busy_o.
//   results: result_valid_o marks each for exactly one cycle; no back pressure.
//   config: cfg_data_i sets the active size while idle; above MAX_DIM clamps.
//   reset: both stores read as zero, active size is zero, nothing in flight.
module matrix_multiply_coprocessor #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        cmd_i,
  input  logic [mmc_pkg::IDX_W-1:0]         elem_row_i,
  input  logic [mmc_pkg::IDX_W-1:0]         elem_col_i,
  input  logic signed [mmc_pkg::VAL_W-1:0]  elem_value_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mmc_pkg::SIZE_W-1:0]        cfg_data_i,
  output logic                              result_valid_o,
  output logic [mmc_pkg::IDX_W-1:0]         out_row_o,
  output logic [mmc_pkg::IDX_W-1:0]         out_col_o,
  output logic signed [mmc_pkg::VAL_W-1:0]  product_value_o,
  output logic                              last_o
);

  mmc_pkg::mmc_wr_t     wr;
  mmc_pkg::mmc_issue_t  issue;
  mmc_pkg::mmc_status_t status;

  mmc_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .elem_row_i   (elem_row_i),
    .elem_col_i   (elem_col_i),
    .elem_value_i (elem_value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .status_i     (status),
    .busy_o       (busy_o),
    .cfg_ready_o  (cfg_ready_o),
    .wr_o         (wr),
    .issue_o      (issue)
  );

  mmc_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .issue_i         (issue),
    .status_o        (status),
    .result_valid_o  (result_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

endmodule
